FILE: hdl/dfrem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfrem_pkg
// Widths, codes and shared types of the binary64 remainder core.
// ----------------------------------------------------------------------------
package dfrem_pkg;

   localparam int MAN_W  = 52;
   localparam int EXP_W  = 11;
   localparam int SIG_W  = MAN_W + 1;
   localparam int ACC_W  = SIG_W + 1;
   localparam int EXPS_W = 13;

   localparam logic [EXP_W-1:0]         EXP_MAX   = 11'h7ff;
   localparam logic [63:0]              QNAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic signed [EXPS_W-1:0] EXP_ZERO  = 13'sd0;
   localparam logic signed [EXPS_W-1:0] EXP_ONE   = 13'sd1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETUP  = 7'b0000010,
      ST_UNPACK = 7'b0000100,
      ST_DIVIDE = 7'b0001000,
      ST_NORM   = 7'b0010000,
      ST_DENORM = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [ACC_W-1:0] keep;
      logic             zero;
   } step_type;

endpackage
`default_nettype wire

FILE: hdl/dfrem_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfrem_req_if
// Request channel: dividend and divisor bit patterns.
// ----------------------------------------------------------------------------
interface dfrem_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] dividend_bits;
   logic [63:0] divisor_bits;

   modport source (output valid, output dividend_bits, output divisor_bits, input ready);
   modport sink   (input valid, input dividend_bits, input divisor_bits, output ready);
endinterface
`default_nettype wire

FILE: hdl/dfrem_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfrem_rsp_if
// Response channel: remainder bit pattern and invalid flag.
// ----------------------------------------------------------------------------
interface dfrem_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] remainder_bits;
   logic        invalid;

   modport source (output valid, output remainder_bits, output invalid, input ready);
   modport sink   (input valid, input remainder_bits, input invalid, output ready);
endinterface
`default_nettype wire

FILE: hdl/dfrem_divstep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfrem_divstep
// Restoring subtract unit: trial subtract of the divisor mantissa, keep the
// difference when non-negative, flag an exact zero.
// ----------------------------------------------------------------------------
module dfrem_divstep
   import dfrem_pkg::*;
(
   input  wire logic [ACC_W-1:0] acc,
   input  wire logic [SIG_W-1:0] divisor,
   output step_type              step_out
);

   logic [ACC_W:0] diff;

   assign diff = {1'b0, acc} - {2'b00, divisor};

   always_comb begin
      step_out.keep = diff[ACC_W] ? acc : diff[ACC_W-1:0];
      step_out.zero = (diff == '0);
   end

endmodule
`default_nettype wire

FILE: hdl/double_float_remainder_core.sv
`default_nettype none
// Sequence: special cases resolve in setup and go straight to the completion state;
//   otherwise unpack shifts subnormal operands up, divide retires one bit per cycle
//   through the subtractor over the exponent difference, renormalize shifts the
//   remainder up, and denormalize shifts a subnormal result down.
// Throughput: one request at a time; the next request is taken from the cycle after the
//   result loads the output register. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// double_float_remainder_core
// Truncated binary64 remainder by iterative restoring shift-subtract.
// ----------------------------------------------------------------------------
module double_float_remainder_core
   import dfrem_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   dfrem_req_if.sink   req_chan,
   dfrem_rsp_if.source rsp_chan
);

   state_type                state_ff, state_in;
   logic [63:0]              a_ff, a_in, b_ff, b_in;
   logic [ACC_W-1:0]         ma_ff, ma_in;
   logic [SIG_W-1:0]         mb_ff, mb_in;
   logic signed [EXPS_W-1:0] ea_ff, ea_in, eb_ff, eb_in;
   logic [63:0]              res_ff, res_in;
   logic                     inv_ff, inv_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              rsp_bits_ff, rsp_bits_in;
   logic                     rsp_inv_ff, rsp_inv_in;

   logic [EXP_W-1:0] a_exp, b_exp;
   logic [MAN_W-1:0] a_frac, b_frac;
   logic             b_nan, op_invalid, a_le_b, a_eq_b, sign;
   logic             req_fire, rsp_free;
   step_type         step;

   dfrem_divstep u_divstep (
      .acc      (ma_ff),
      .divisor  (mb_ff),
      .step_out (step)
   );

   assign a_exp      = a_ff[62:52];
   assign b_exp      = b_ff[62:52];
   assign a_frac     = a_ff[MAN_W-1:0];
   assign b_frac     = b_ff[MAN_W-1:0];
   assign sign       = a_ff[63];
   assign b_nan      = (b_exp == EXP_MAX) && (b_frac != '0);
   assign op_invalid = (b_ff[62:0] == '0) || b_nan || (a_exp == EXP_MAX);
   assign a_le_b     = a_ff[62:0] <= b_ff[62:0];
   assign a_eq_b     = a_ff[62:0] == b_ff[62:0];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      res_in       = res_ff;
      inv_in       = inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_inv_in   = rsp_inv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               a_in     = req_chan.dividend_bits;
               b_in     = req_chan.divisor_bits;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            inv_in = 1'b0;
            if (op_invalid) begin
               res_in   = QNAN_BITS;
               inv_in   = 1'b1;
               state_in = ST_DONE;
            end else if (a_le_b) begin
               res_in   = a_eq_b ? {sign, 63'b0} : a_ff;
               state_in = ST_DONE;
            end else begin
               ma_in    = (a_exp == '0) ? {2'b00, a_frac} : {2'b01, a_frac};
               mb_in    = (b_exp == '0) ? {1'b0, b_frac} : {1'b1, b_frac};
               ea_in    = (a_exp == '0) ? EXP_ONE
                                        : $signed({{(EXPS_W-EXP_W){1'b0}}, a_exp});
               eb_in    = (b_exp == '0) ? EXP_ONE
                                        : $signed({{(EXPS_W-EXP_W){1'b0}}, b_exp});
               state_in = ST_UNPACK;
            end
         end
         ST_UNPACK: begin
            if (!ma_ff[MAN_W]) begin
               ma_in = {ma_ff[ACC_W-2:0], 1'b0};
               ea_in = ea_ff - EXP_ONE;
            end
            if (!mb_ff[MAN_W]) begin
               mb_in = {mb_ff[SIG_W-2:0], 1'b0};
               eb_in = eb_ff - EXP_ONE;
            end
            if (ma_ff[MAN_W] && mb_ff[MAN_W]) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step.zero) begin
               res_in   = {sign, 63'b0};
               state_in = ST_DONE;
            end else if (ea_ff > eb_ff) begin
               ma_in = {step.keep[ACC_W-2:0], 1'b0};
               ea_in = ea_ff - EXP_ONE;
            end else begin
               ma_in    = step.keep;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!ma_ff[MAN_W]) begin
               ma_in = {ma_ff[ACC_W-2:0], 1'b0};
               ea_in = ea_ff - EXP_ONE;
            end else if (ea_ff > EXP_ZERO) begin
               res_in   = {sign, ea_ff[EXP_W-1:0], ma_ff[MAN_W-1:0]};
               state_in = ST_DONE;
            end else begin
               state_in = ST_DENORM;
            end
         end
         ST_DENORM: begin
            if (ea_ff == EXP_ONE) begin
               res_in   = {sign, {(63-SIG_W){1'b0}}, ma_ff[SIG_W-1:0]};
               state_in = ST_DONE;
            end else begin
               ma_in = {1'b0, ma_ff[ACC_W-1:1]};
               ea_in = ea_ff + EXP_ONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = res_ff;
               rsp_inv_in   = inv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      res_ff      <= res_in;
      inv_ff      <= inv_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_inv_ff  <= rsp_inv_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.remainder_bits = rsp_bits_ff;
   assign rsp_chan.invalid        = rsp_inv_ff;

`ifndef SYNTHESIS
   a_div_exp_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> ea_ff >= eb_ff)
      else $error("dividend exponent fell below divisor exponent during divide");

   a_div_normalized: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> mb_ff[MAN_W] && ma_ff < {mb_ff, 1'b0})
      else $error("partial remainder out of range during divide");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the completion state");

   a_idle_after_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_free |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("result load did not return the sequencer to idle");
`endif

endmodule
`default_nettype wire
